### sv/string_literal_escape_converter_defines.svh
// assertion macros for the string literal escape converter
`ifndef STRING_LITERAL_ESCAPE_CONVERTER_DEFINES_SVH
`define STRING_LITERAL_ESCAPE_CONVERTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sle_pkg.sv
// types, codes and helper functions shared by the string literal converter
package sle_pkg;

  // input item
  typedef struct packed {
    logic       action;
    logic [7:0] ch;
    logic       is_final;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
    logic       needs_hex;
    logic [1:0] error_code;
  } out_item_t;

  // classify scanner states
  typedef enum logic [2:0] {
    SC_NORMAL,
    SC_ESC,
    SC_X,
    SC_X2,
    SC_X3,
    SC_N,
    SC_SKIP,
    SC_DONE
  } scan_state_t;

  // convert decoder states
  typedef enum logic [1:0] {
    ES_IDLE,
    ES_BS,
    ES_X,
    ES_X1
  } esc_state_t;

  // what follows the leading part of a command
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_SINGLE,
    TAIL_REG,
    TAIL_HEX
  } tail_t;

  // command from front to back: everything one item produces
  typedef struct packed {
    logic       lead;
    logic       emit;
    logic [7:0] value;
    tail_t      tail;
    logic       hex;
    logic [1:0] err;
  } cmd_t;

  // hex digit decode result
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // actions
  localparam logic ACT_CLASSIFY = 1'b0;
  localparam logic ACT_CONVERT  = 1'b1;

  // error codes
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN = 2'd1;
  localparam logic [1:0] ERR_BAD_HEX = 2'd2;
  localparam logic [1:0] ERR_TRUNC   = 2'd3;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_APOS   = 8'd39;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_TWO    = 8'd50;
  localparam logic [7:0] CH_THREE  = 8'd51;
  localparam logic [7:0] CH_COLON  = 8'd58;
  localparam logic [7:0] CH_UC_A   = 8'd65;
  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_LC_N   = 8'd110;
  localparam logic [7:0] CH_LC_R   = 8'd114;
  localparam logic [7:0] CH_LC_T   = 8'd116;
  localparam logic [7:0] CH_LC_X   = 8'd120;

  // nibble to upper-case hex character
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_ZERO + {4'b0000, d};
    end else begin
      r = 8'd55 + {4'b0000, d};
    end
    return r;
  endfunction

  // hex character to nibble; digits and both letter cases
  function automatic digit_t digit_value(input logic [7:0] c);
    digit_t r;
    r.ok  = 1'b0;
    r.val = c[3:0];
    if (c >= 8'd48 && c <= 8'd57) begin
      r.ok = 1'b1;
    end else if ((c >= 8'd65 && c <= 8'd70) || (c >= 8'd97 && c <= 8'd102)) begin
      r.ok  = 1'b1;
      r.val = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

### sv/sle_front.sv
// front: accepts items, runs the scanner and decoder state, builds commands
module sle_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sle_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             push,
  output sle_pkg::cmd_t    cmd
);

  sle_pkg::scan_state_t scan_r, scan_nxt;
  sle_pkg::esc_state_t  esc_r, esc_nxt;
  logic       odd_r, odd_nxt;
  logic       hex_mode_r, hex_mode_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic [3:0] held_r, held_nxt;
  logic       failed_r, failed_nxt;

  logic                 accept;
  sle_pkg::digit_t      dig;
  sle_pkg::scan_state_t scan_new;
  logic                 odd_new;
  logic                 trunc;
  sle_pkg::esc_state_t  esc_new;
  logic [3:0]           held_new;
  logic                 fail_now;
  logic [1:0]           fail_err;
  logic                 emit_now;
  logic [7:0]           emit_val;
  logic                 conv_active;
  logic                 lead_now;
  logic                 dec_on;
  logic [1:0]           pos_inc;

  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;
  assign dig      = sle_pkg::digit_value(in_data.ch);
  assign pos_inc  = (pos_r == 2'd2) ? pos_r : pos_r + 2'd1;

  // classify scan step
  always_comb begin
    scan_new = scan_r;
    case (scan_r)
      sle_pkg::SC_ESC: begin
        if (in_data.ch == sle_pkg::CH_LC_X) begin
          scan_new = sle_pkg::SC_X;
        end else if (in_data.ch == sle_pkg::CH_LC_N) begin
          scan_new = sle_pkg::SC_N;
        end else if (in_data.ch == sle_pkg::CH_LC_T) begin
          scan_new = sle_pkg::SC_NORMAL;
        end else if (in_data.ch == sle_pkg::CH_QUOTE) begin
          scan_new = sle_pkg::SC_DONE;
        end else begin
          scan_new = sle_pkg::SC_SKIP;
        end
      end
      sle_pkg::SC_X: begin
        if (in_data.ch == sle_pkg::CH_TWO) begin
          scan_new = sle_pkg::SC_X2;
        end else if (in_data.ch == sle_pkg::CH_THREE) begin
          scan_new = sle_pkg::SC_X3;
        end else if (dig.ok && (dig.val < 4'd2 || dig.val > 4'd7)) begin
          scan_new = sle_pkg::SC_DONE;
        end else begin
          scan_new = sle_pkg::SC_NORMAL;
        end
      end
      sle_pkg::SC_X2, sle_pkg::SC_X3, sle_pkg::SC_N: begin
        if ((scan_r == sle_pkg::SC_X2 && in_data.ch == sle_pkg::CH_TWO) ||
            (scan_r == sle_pkg::SC_X3 && in_data.ch == sle_pkg::CH_UC_A) ||
            (scan_r == sle_pkg::SC_N && in_data.ch == sle_pkg::CH_COLON)) begin
          scan_new = sle_pkg::SC_DONE;
        end else if (in_data.ch == sle_pkg::CH_BSLASH) begin
          scan_new = sle_pkg::SC_ESC;
        end else begin
          scan_new = sle_pkg::SC_NORMAL;
        end
      end
      sle_pkg::SC_SKIP: begin
        scan_new = sle_pkg::SC_NORMAL;
      end
      sle_pkg::SC_DONE: begin
        scan_new = sle_pkg::SC_DONE;
      end
      default: begin
        scan_new = (in_data.ch == sle_pkg::CH_BSLASH) ? sle_pkg::SC_ESC : sle_pkg::SC_NORMAL;
      end
    endcase
    odd_new = odd_r || (scan_new == sle_pkg::SC_DONE) ||
              (pos_r == 2'd1 && in_data.ch == sle_pkg::CH_COLON);
    trunc   = (scan_new == sle_pkg::SC_ESC) || (scan_new == sle_pkg::SC_X) ||
              (scan_new == sle_pkg::SC_SKIP);
  end

  // convert escape decode step
  always_comb begin
    esc_new  = esc_r;
    held_new = held_r;
    fail_now = 1'b0;
    fail_err = sle_pkg::ERR_OK;
    emit_now = 1'b0;
    emit_val = in_data.ch;
    case (esc_r)
      sle_pkg::ES_BS: begin
        esc_new  = sle_pkg::ES_IDLE;
        emit_now = 1'b1;
        case (in_data.ch)
          sle_pkg::CH_LC_X: begin
            esc_new  = sle_pkg::ES_X;
            emit_now = 1'b0;
          end
          sle_pkg::CH_LC_N:   emit_val = sle_pkg::CH_NL;
          sle_pkg::CH_LC_T:   emit_val = sle_pkg::CH_TAB;
          sle_pkg::CH_LC_R:   emit_val = sle_pkg::CH_CR;
          sle_pkg::CH_BSLASH,
          sle_pkg::CH_APOS,
          sle_pkg::CH_QUOTE:  emit_val = in_data.ch;
          default: begin
            emit_now = 1'b0;
            fail_now = 1'b1;
            fail_err = sle_pkg::ERR_UNKNOWN;
          end
        endcase
      end
      sle_pkg::ES_X: begin
        if (dig.ok) begin
          held_new = dig.val;
          esc_new  = sle_pkg::ES_X1;
        end else begin
          esc_new  = sle_pkg::ES_IDLE;
          fail_now = 1'b1;
          fail_err = sle_pkg::ERR_BAD_HEX;
        end
      end
      sle_pkg::ES_X1: begin
        esc_new = sle_pkg::ES_IDLE;
        if (dig.ok) begin
          emit_now = 1'b1;
          emit_val = {held_r, dig.val};
        end else begin
          fail_now = 1'b1;
          fail_err = sle_pkg::ERR_BAD_HEX;
        end
      end
      default: begin
        if (in_data.ch == sle_pkg::CH_BSLASH) begin
          esc_new = sle_pkg::ES_BS;
        end else begin
          emit_now = 1'b1;
        end
      end
    endcase
    conv_active = (in_data.action == sle_pkg::ACT_CONVERT) && !failed_r;
    lead_now    = conv_active && hex_mode_r && (pos_r == 2'd0);
    dec_on      = conv_active && !lead_now;
  end

  // next state
  always_comb begin
    scan_nxt     = scan_r;
    esc_nxt      = esc_r;
    odd_nxt      = odd_r;
    hex_mode_nxt = hex_mode_r;
    pos_nxt      = pos_r;
    held_nxt     = held_r;
    failed_nxt   = failed_r;
    if (accept) begin
      if (in_data.action == sle_pkg::ACT_CLASSIFY) begin
        scan_nxt = scan_new;
        odd_nxt  = odd_new;
        if (in_data.is_final) begin
          hex_mode_nxt = odd_new;
        end
      end else if (dec_on) begin
        esc_nxt    = esc_new;
        held_nxt   = held_new;
        failed_nxt = fail_now;
      end
      if (in_data.is_final) begin
        scan_nxt   = sle_pkg::SC_NORMAL;
        esc_nxt    = sle_pkg::ES_IDLE;
        odd_nxt    = 1'b0;
        pos_nxt    = 2'd0;
        held_nxt   = 4'd0;
        failed_nxt = 1'b0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
  end

  // command for the back end
  always_comb begin
    cmd       = '0;
    cmd.tail  = sle_pkg::TAIL_NONE;
    cmd.value = emit_val;
    if (in_data.action == sle_pkg::ACT_CLASSIFY) begin
      cmd.hex = odd_new;
      if (in_data.is_final) begin
        cmd.tail = sle_pkg::TAIL_SINGLE;
        cmd.err  = trunc ? sle_pkg::ERR_TRUNC : sle_pkg::ERR_OK;
      end
    end else begin
      cmd.hex  = hex_mode_r;
      cmd.lead = lead_now;
      cmd.emit = dec_on && emit_now;
      if (dec_on && fail_now) begin
        cmd.tail = sle_pkg::TAIL_SINGLE;
        cmd.err  = fail_err;
      end else if (conv_active && in_data.is_final) begin
        if ((dec_on ? esc_new : esc_r) != sle_pkg::ES_IDLE) begin
          cmd.tail = sle_pkg::TAIL_SINGLE;
          cmd.err  = sle_pkg::ERR_TRUNC;
        end else if (hex_mode_r) begin
          cmd.tail = sle_pkg::TAIL_HEX;
        end else begin
          cmd.tail = sle_pkg::TAIL_REG;
        end
      end
    end
    push = accept && (cmd.lead || cmd.emit || (cmd.tail != sle_pkg::TAIL_NONE));
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r     <= sle_pkg::SC_NORMAL;
      esc_r      <= sle_pkg::ES_IDLE;
      odd_r      <= 1'b0;
      hex_mode_r <= 1'b0;
      pos_r      <= 2'd0;
      held_r     <= 4'd0;
      failed_r   <= 1'b0;
    end else begin
      scan_r     <= scan_nxt;
      esc_r      <= esc_nxt;
      odd_r      <= odd_nxt;
      hex_mode_r <= hex_mode_nxt;
      pos_r      <= pos_nxt;
      held_r     <= held_nxt;
      failed_r   <= failed_nxt;
    end
  end

endmodule

### sv/sle_queue.sv
// command queue between front and back
module sle_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sle_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output sle_pkg::cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sle_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/sle_back.sv
// back: expands each command into result items, one per cycle unless out_stall holds the output
module sle_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  sle_pkg::cmd_t      head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output sle_pkg::out_item_t out_data
);

  logic [2:0]         step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  sle_pkg::out_item_t out_data_r;

  logic               load;
  logic               fire;
  logic [1:0]         n_first;
  logic [2:0]         n_tail;
  logic [3:0]         total;
  logic               last;
  logic               in_tail;
  logic [2:0]         t_idx;
  sle_pkg::out_item_t res;

  assign load = !out_valid_r || !out_stall;
  assign fire = !q_empty && load;

  // segment lengths of the current command
  always_comb begin
    if (head.lead) begin
      n_first = 2'd1;
    end else if (head.emit) begin
      n_first = head.hex ? 2'd3 : 2'd1;
    end else begin
      n_first = 2'd0;
    end
    case (head.tail)
      sle_pkg::TAIL_SINGLE: n_tail = 3'd1;
      sle_pkg::TAIL_REG:    n_tail = 3'd2;
      sle_pkg::TAIL_HEX:    n_tail = 3'd5;
      default:              n_tail = 3'd0;
    endcase
    total   = {2'b00, n_first} + {1'b0, n_tail};
    last    = ({1'b0, step_r} == total - 4'd1);
    in_tail = ({1'b0, step_r} >= {2'b00, n_first});
    t_idx   = step_r - {1'b0, n_first};
  end

  // result item for the current step
  always_comb begin
    res.out_char   = sle_pkg::CH_NUL;
    res.run_end    = in_tail && last;
    res.needs_hex  = head.hex;
    res.error_code = sle_pkg::ERR_OK;
    if (!in_tail) begin
      if (head.lead) begin
        res.out_char = sle_pkg::CH_APOS;
      end else if (!head.hex) begin
        res.out_char = head.value;
      end else begin
        case (step_r[1:0])
          2'd0:    res.out_char = sle_pkg::CH_SPACE;
          2'd1:    res.out_char = sle_pkg::hex_char(head.value[7:4]);
          default: res.out_char = sle_pkg::hex_char(head.value[3:0]);
        endcase
      end
    end else begin
      case (head.tail)
        sle_pkg::TAIL_SINGLE: begin
          res.error_code = head.err;
        end
        sle_pkg::TAIL_REG: begin
          res.out_char = (t_idx == 3'd0) ? sle_pkg::CH_QUOTE : sle_pkg::CH_NL;
        end
        sle_pkg::TAIL_HEX: begin
          case (t_idx)
            3'd0:    res.out_char = sle_pkg::CH_SPACE;
            3'd1:    res.out_char = sle_pkg::CH_ZERO;
            3'd2:    res.out_char = sle_pkg::CH_ZERO;
            3'd3:    res.out_char = sle_pkg::CH_APOS;
            default: res.out_char = sle_pkg::CH_NL;
          endcase
        end
        default: begin
          res.out_char = sle_pkg::CH_NUL;
        end
      endcase
    end
  end

  // step counter and output valid
  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    q_pop         = fire && last;
    if (fire) begin
      out_valid_nxt = 1'b1;
      step_nxt      = last ? 3'd0 : step_r + 3'd1;
    end else if (load) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/string_literal_escape_converter.sv
// top level of the string literal escape converter
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | in_data  (action, ch, is_final)
//   out     | output    | out_valid / out_stall | out_data (out_char, run_end,
//           |           |                       |           needs_hex, error_code)
//
// the front takes one item per cycle while the command queue has room.
// the back sends one result item per cycle unless out_stall holds it: a regular byte gives one
// result item, a hex-mode byte three, and a final byte up to eight (hex byte plus trailer).
// a result passes through the command queue and then the output register before it is offered.
// rst_n is synchronous, active low, and clears all pass state and hex_mode.
// out_stall holds the output register; once the queue fills, in_stall rises.
module string_literal_escape_converter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sle_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sle_pkg::out_item_t out_data
);

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  sle_pkg::cmd_t q_in;
  sle_pkg::cmd_t q_head;

  // item intake and classification
  sle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (q_push),
    .cmd      (q_in)
  );

  // decoupling queue
  sle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // result expansion
  sle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sv/sle_checker.sv
// port-level checks for the string literal escape converter
`include "string_literal_escape_converter_defines.svh"

module sle_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input sle_pkg::out_item_t out_data
);

  // a stalled result item stays offered
  `SLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out_valid dropped while stalled")

  // a stalled result item keeps its payload
  `SLE_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "out_data changed while stalled")

  // an error result ends the pass and carries no character
  `SLE_ASSERT_NOW(a_err_ends, out_valid && out_data.error_code != sle_pkg::ERR_OK, out_data.run_end && out_data.out_char == sle_pkg::CH_NUL, "error result without run_end or with a character")

  // a pass that ends cleanly ends on a newline or on the classify verdict
  `SLE_ASSERT_NOW(a_end_char, out_valid && out_data.run_end && out_data.error_code == sle_pkg::ERR_OK, out_data.out_char == sle_pkg::CH_NL || out_data.out_char == sle_pkg::CH_NUL, "clean pass end with an unexpected character")

  // results before the end of a pass never carry an error
  `SLE_ASSERT_NOW(a_mid_ok, out_valid && !out_data.run_end, out_data.error_code == sle_pkg::ERR_OK, "error code on a result that does not end the pass")

endmodule

bind string_literal_escape_converter sle_checker u_sle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### test/string_literal_escape_converter_tb.sv
// self-checking testbench for the string literal escape converter
module string_literal_escape_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  localparam int unsigned QUIET_LIMIT = 400;
  localparam int unsigned SETTLE_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  // listing characters still owed by the block, oldest first
  out_item_t listing_q[$];
  out_item_t want_item;
  string bad_fields;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  bit calm = 1'b0;
  logic [7:0] lit_bytes[$];
  string hex_digits = "0123456789ABCDEF";

  // predictor copy of the block state
  scan_state_t scan_st;
  esc_state_t esc_st;
  logic odd_seen;
  logic hex_listing;
  logic pass_failed;
  logic [1:0] byte_pos;
  logic [7:0] held_hi;

  string_literal_escape_converter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  // hex digit value, -1 when not a hex digit
  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return int'(c) - 48;
    end else if (c >= "A" && c <= "F") begin
      return int'(c) - 55;
    end else if (c >= "a" && c <= "f") begin
      return int'(c) - 87;
    end
    return -1;
  endfunction

  // classify scanner, one byte
  function automatic scan_state_t scan_next(scan_state_t s, logic [7:0] c);
    scan_state_t plain;
    plain = (c == CH_BSLASH) ? SC_ESC : SC_NORMAL;
    case (s)
      SC_ESC: begin
        if (c == CH_LC_X) return SC_X;
        else if (c == CH_LC_N) return SC_N;
        else if (c == CH_LC_T) return SC_NORMAL;
        else if (c == CH_QUOTE) return SC_DONE;
        return SC_SKIP;
      end
      SC_X: begin
        if (c == CH_TWO) return SC_X2;
        else if (c == CH_THREE) return SC_X3;
        else if (c == "0" || c == "1" || c == "8" || c == "9" ||
                 (c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return SC_DONE;
        return SC_NORMAL;
      end
      SC_X2: return (c == CH_TWO) ? SC_DONE : plain;
      SC_X3: return (c == CH_UC_A) ? SC_DONE : plain;
      SC_N: return (c == CH_COLON) ? SC_DONE : plain;
      SC_SKIP: return SC_NORMAL;
      SC_DONE: return SC_DONE;
      default: return plain;
    endcase
  endfunction

  task automatic push_char(logic [7:0] c, logic last, logic hx, logic [1:0] err);
    out_item_t r;
    r.out_char = c;
    r.run_end = last;
    r.needs_hex = hx;
    r.error_code = err;
    listing_q.push_back(r);
  endtask

  // decoded byte: raw in regular mode, space and two digits in hex mode
  task automatic put_value(logic [7:0] v);
    if (hex_listing) begin
      push_char(CH_SPACE, 1'b0, 1'b1, ERR_OK);
      push_char(hex_digits[v[7:4]], 1'b0, 1'b1, ERR_OK);
      push_char(hex_digits[v[3:0]], 1'b0, 1'b1, ERR_OK);
    end else begin
      push_char(v, 1'b0, 1'b0, ERR_OK);
    end
  endtask

  task automatic flag_error(logic [1:0] err);
    push_char(CH_NUL, 1'b1, hex_listing, err);
    pass_failed = 1'b1;
  endtask

  task automatic clear_pass();
    scan_st = SC_NORMAL;
    esc_st = ES_IDLE;
    odd_seen = 1'b0;
    pass_failed = 1'b0;
    byte_pos = 2'd0;
    held_hi = 8'd0;
  endtask

  // escape decoder, one byte of the convert pass
  task automatic convert_step(logic [7:0] c);
    int d;
    if (hex_listing && byte_pos == 2'd0) begin
      push_char(CH_APOS, 1'b0, 1'b1, ERR_OK);
      return;
    end
    case (esc_st)
      ES_BS: begin
        esc_st = ES_IDLE;
        if (c == CH_LC_X) esc_st = ES_X;
        else if (c == CH_LC_N) put_value(CH_NL);
        else if (c == CH_LC_T) put_value(CH_TAB);
        else if (c == CH_BSLASH) put_value(CH_BSLASH);
        else if (c == CH_APOS) put_value(CH_APOS);
        else if (c == CH_QUOTE) put_value(CH_QUOTE);
        else if (c == CH_LC_R) put_value(CH_CR);
        else flag_error(ERR_UNKNOWN);
      end
      ES_X: begin
        d = hex_nibble(c);
        if (d < 0) begin
          esc_st = ES_IDLE;
          flag_error(ERR_BAD_HEX);
        end else begin
          held_hi = d[7:0];
          esc_st = ES_X1;
        end
      end
      ES_X1: begin
        esc_st = ES_IDLE;
        d = hex_nibble(c);
        if (d < 0) flag_error(ERR_BAD_HEX);
        else put_value({held_hi[3:0], d[3:0]});
      end
      default: begin
        if (c == CH_BSLASH) esc_st = ES_BS;
        else put_value(c);
      end
    endcase
  endtask

  // expected listing characters for one accepted item
  task automatic predict_listing(in_item_t it);
    logic [1:0] trunc;
    if (it.action == ACT_CLASSIFY) begin
      scan_st = scan_next(scan_st, it.ch);
      if (scan_st == SC_DONE) odd_seen = 1'b1;
      if (byte_pos == 2'd1 && it.ch == CH_COLON) odd_seen = 1'b1;
      if (it.is_final) begin
        trunc = (scan_st inside {SC_ESC, SC_X, SC_SKIP}) ? ERR_TRUNC : ERR_OK;
        hex_listing = odd_seen;
        push_char(CH_NUL, 1'b1, odd_seen, trunc);
        clear_pass();
        return;
      end
    end else begin
      if (!pass_failed) begin
        convert_step(it.ch);
        if (it.is_final && !pass_failed) begin
          if (esc_st != ES_IDLE) begin
            push_char(CH_NUL, 1'b1, hex_listing, ERR_TRUNC);
          end else if (hex_listing) begin
            push_char(CH_SPACE, 1'b0, 1'b1, ERR_OK);
            push_char(CH_ZERO, 1'b0, 1'b1, ERR_OK);
            push_char(CH_ZERO, 1'b0, 1'b1, ERR_OK);
            push_char(CH_APOS, 1'b0, 1'b1, ERR_OK);
            push_char(CH_NL, 1'b1, 1'b1, ERR_OK);
          end else begin
            push_char(CH_QUOTE, 1'b0, 1'b0, ERR_OK);
            push_char(CH_NL, 1'b1, 1'b0, ERR_OK);
          end
        end
      end
      if (it.is_final) begin
        clear_pass();
        return;
      end
    end
    if (byte_pos < 2'd2) byte_pos++;
  endtask

  // one input item, after a random gap
  task automatic send_item(logic act, logic [7:0] c, logic last);
    int unsigned gap;
    in_item_t it;
    gap = calm ? 0 : $urandom_range(0, 4);
    it.action = act;
    it.ch = c;
    it.is_final = last;
    if (gap != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    predict_listing(it);
    items_sent++;
  endtask

  task automatic send_text(logic act, string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(act, s[i], i == s.len() - 1);
    end
  endtask

  task automatic send_literal(logic act);
    foreach (lit_bytes[i]) begin
      send_item(act, lit_bytes[i], i == lit_bytes.size() - 1);
    end
  endtask

  // hold the input back until the block has caught up
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (listing_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hex_digit();
    string pool;
    pool = "0123456789abcdefABCDEF";
    return pool[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  // random literal built from escape pieces, sometimes cut short
  task automatic make_literal();
    logic [7:0] c;
    lit_bytes = {};
    lit_bytes.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 12))
        0: begin
          if ($urandom_range(0, 3) == 0) begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
          end else begin
            do c = 8'($urandom_range(32, 126)); while (c == CH_BSLASH);
          end
          lit_bytes.push_back(c);
        end
        1: lit_bytes = {lit_bytes, CH_BSLASH, CH_LC_N};
        2: lit_bytes = {lit_bytes, CH_BSLASH, CH_LC_T};
        3: lit_bytes = {lit_bytes, CH_BSLASH, CH_BSLASH};
        4: lit_bytes = {lit_bytes, CH_BSLASH, CH_APOS};
        5: lit_bytes = {lit_bytes, CH_BSLASH, CH_QUOTE};
        6: lit_bytes = {lit_bytes, CH_BSLASH, CH_LC_R};
        7: lit_bytes = {lit_bytes, CH_BSLASH, CH_LC_X, rand_hex_digit(), rand_hex_digit()};
        8: begin
          if ($urandom_range(0, 1) == 0) lit_bytes = {lit_bytes, CH_BSLASH, CH_LC_X, CH_TWO, CH_TWO};
          else lit_bytes = {lit_bytes, CH_BSLASH, CH_LC_X, CH_THREE, CH_UC_A};
        end
        9: lit_bytes = {lit_bytes, CH_BSLASH, CH_LC_N, CH_COLON};
        10: lit_bytes = {lit_bytes, CH_BSLASH, 8'($urandom_range(0, 255))};
        11: begin
          if ($urandom_range(0, 1) == 0) lit_bytes = {lit_bytes, CH_BSLASH, CH_LC_X, rand_non_hex()};
          else lit_bytes = {lit_bytes, CH_BSLASH, CH_LC_X, rand_hex_digit(), rand_non_hex()};
        end
        default: lit_bytes.push_back(CH_COLON);
      endcase
    end
    // literal ending inside an escape
    if ($urandom_range(0, 7) == 0) begin
      lit_bytes.push_back(CH_BSLASH);
      if ($urandom_range(0, 1) == 0) lit_bytes.push_back(CH_LC_X);
    end else begin
      lit_bytes.push_back(CH_QUOTE);
    end
  endtask

  // hand-picked literals for the corner cases
  task automatic test_directed();
    // colon as second byte selects hex mode
    send_text(ACT_CLASSIFY, "\":");
    // leading byte, then hex listing of raw 0xFF and a mixed-case hex escape
    send_item(ACT_CONVERT, 8'h00, 1'b0);
    send_item(ACT_CONVERT, 8'hFF, 1'b0);
    send_text(ACT_CONVERT, "\\xaF");
    // lone backslash at the end of a classify pass
    send_text(ACT_CLASSIFY, "\"\\");
    // regular decode, then unknown escape and the bytes after it
    send_text(ACT_CONVERT, "\"\\n\\r\\qz");
    // bad hex digit
    send_text(ACT_CONVERT, "\\xga");
    // convert pass ending inside an escape
    send_text(ACT_CONVERT, "\"\\");
    // newline escape followed by a colon
    send_text(ACT_CLASSIFY, "\"\\n:\"");
    wait_drained();
  endtask

  // classify then convert the same literal, as the block is used
  task automatic test_literal_pairs(int unsigned target);
    int unsigned count;
    count = 0;
    while (items_sent < target) begin
      make_literal();
      case ($urandom_range(0, 7))
        0: send_literal(ACT_CONVERT);
        1: send_literal(ACT_CLASSIFY);
        default: begin
          send_literal(ACT_CLASSIFY);
          send_literal(ACT_CONVERT);
        end
      endcase
      count++;
      if (count % 3 == 0) wait_drained();
    end
  endtask

  // same traffic with neither side idling
  task automatic test_back_to_back(int unsigned target);
    calm = 1'b1;
    test_literal_pairs(target);
    calm = 1'b0;
  endtask

  // random bytes, mixed actions and stray ends
  task automatic test_noise(int unsigned n);
    repeat (n - 1) begin
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                $urandom_range(0, 3) == 0);
    end
    send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
  endtask

  // result side stall, drawn per result
  initial begin : result_sink
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 4);
      if (hold != 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (hold - 1) @(negedge clk);
        @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (listing_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        want_item = listing_q.pop_front();
        bad_fields = "";
        if (out_data.out_char !== want_item.out_char) bad_fields = {bad_fields, " out_char"};
        if (out_data.run_end !== want_item.run_end) bad_fields = {bad_fields, " run_end"};
        if (out_data.needs_hex !== want_item.needs_hex) bad_fields = {bad_fields, " needs_hex"};
        if (out_data.error_code !== want_item.error_code) bad_fields = {bad_fields, " error_code"};
        if (bad_fields != "") begin
          report_mismatch($sformatf("result %0d%s: got %p, want %p",
                                    results_seen, bad_fields, out_data, want_item));
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[string_literal_escape_converter] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    clear_pass();
    hex_listing = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_literal_pairs(items_sent + 35);
    test_back_to_back(items_sent + 15);
    test_noise(15);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && listing_q.size() == 0) begin
      $display("[string_literal_escape_converter] OK");
    end else begin
      $display("[string_literal_escape_converter] ERROR");
    end
    $finish;
  end

endmodule
